// ----- hw/rtl/dtfp_pkg.sv -----
package dtfp_pkg;

    // Number of fraction digits carried in the result scale
    localparam int FRAC_DIGITS = 6;

    // Powers of ten for small exponents
    function automatic logic [63:0] pow10(input int unsigned n);
        logic [63:0] s;
        s = 64'd1;
        for (int k = 0; k < 9; k++)
        begin
            if (k < n)
            begin
                s = s * 64'd10;
            end
        end
        return s;
    endfunction

    localparam logic [63:0] SCALE       = pow10(FRAC_DIGITS);
    localparam logic [63:0] I64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] I64_MIN_MAG = 64'h8000_0000_0000_0000;
    // One above the largest integer part that can still give an in-range value
    localparam logic [63:0] WHOLE_BOUND = I64_MAX / SCALE + 64'd1;

    localparam int WHOLE_W = $clog2(WHOLE_BOUND + 64'd1);
    localparam int FRAC_W  = $clog2(SCALE);
    localparam int CNT_W   = $clog2(FRAC_DIGITS + 1);
    localparam int WEXT_W  = WHOLE_W + 4;

    // Character codes
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_SIGN  = 5'b00010,
        PH_WHOLE = 5'b00100,
        PH_DOT   = 5'b01000,
        PH_FRAC  = 5'b10000
    } phase_t;

    // Parsed string handed from the scanner to the scaling pipeline
    typedef struct packed {
        logic                neg;
        logic [WHOLE_W-1:0]  whole;
        logic [FRAC_W-1:0]   frac;
        status_t             status;
    } snap_t;

    // Weight of the fraction digit at position count (already aligned)
    function automatic logic [FRAC_W-1:0] digit_weight(input logic [CNT_W-1:0] count);
        logic [63:0] w;
        w = 64'd0;
        if (int'(count) < FRAC_DIGITS)
        begin
            w = pow10(FRAC_DIGITS - 1 - int'(count));
        end
        return w[FRAC_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/dtfp_scan.sv -----
module dtfp_scan
    import dtfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       no_char,
    input  logic       last,
    output logic       snap_valid,
    output snap_t      snap,
    input  logic       snap_ready
);

    phase_t             phase_reg, phase_next, phase_step;
    logic               neg_reg, neg_next, neg_step;
    logic [WHOLE_W-1:0] whole_reg, whole_next, whole_step;
    logic [FRAC_W-1:0]  frac_reg, frac_next, frac_step;
    logic [CNT_W-1:0]   cnt_reg, cnt_next, cnt_step;
    status_t            err_reg, err_next, err_step;
    logic               snap_valid_reg, snap_valid_next;
    snap_t              snap_reg, snap_next;

    logic                in_fire;
    logic                is_digit;
    logic [3:0]          digit_val;
    logic [WEXT_W-1:0]   whole_ext;
    logic [FRAC_W+3:0]   frac_prod;
    status_t             final_status;

    assign in_ready = !snap_valid_reg || snap_ready;
    assign in_fire  = in_valid && in_ready;

    // Digit decode and the two accumulators
    assign is_digit  = char_code inside {[CH_ZERO:CH_NINE]};
    assign digit_val = is_digit ? char_code[3:0] : 4'd0;
    assign whole_ext = ({4'd0, whole_reg} << 3) + ({4'd0, whole_reg} << 1)
                     + WEXT_W'(digit_val);
    assign frac_prod = (FRAC_W + 4)'(digit_val) * (FRAC_W + 4)'(digit_weight(cnt_reg));

    // Character step; first error freezes everything until the end of string
    always_comb
    begin
        phase_step = phase_reg;
        neg_step   = neg_reg;
        whole_step = whole_reg;
        frac_step  = frac_reg;
        cnt_step   = cnt_reg;
        err_step   = err_reg;
        if (!no_char && err_reg == ST_OK)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (char_code == CH_PLUS || char_code == CH_MINUS)
                    begin
                        neg_step   = (char_code == CH_MINUS);
                        phase_step = PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        whole_step = WHOLE_W'(digit_val);
                        phase_step = PH_WHOLE;
                    end
                    else
                    begin
                        err_step = ST_INVALID;
                    end
                end
                PH_SIGN:
                begin
                    if (is_digit)
                    begin
                        whole_step = WHOLE_W'(digit_val);
                        phase_step = PH_WHOLE;
                    end
                    else
                    begin
                        err_step = ST_INVALID;
                    end
                end
                PH_WHOLE:
                begin
                    if (is_digit)
                    begin
                        whole_step = whole_ext[WHOLE_W-1:0];
                        if (whole_ext > WEXT_W'(WHOLE_BOUND))
                        begin
                            err_step = ST_OVERFLOW;
                        end
                    end
                    else if (char_code == CH_DOT)
                    begin
                        phase_step = PH_DOT;
                    end
                    else
                    begin
                        err_step = ST_INVALID;
                    end
                end
                PH_DOT, PH_FRAC:
                begin
                    if (!is_digit || cnt_reg >= CNT_W'(FRAC_DIGITS))
                    begin
                        err_step = ST_INVALID;
                    end
                    else
                    begin
                        frac_step  = frac_reg + frac_prod[FRAC_W-1:0];
                        cnt_step   = cnt_reg + CNT_W'(1);
                        phase_step = PH_FRAC;
                    end
                end
                default:
                begin
                    err_step = ST_INVALID;
                end
            endcase
        end
    end

    // End-of-string status
    always_comb
    begin
        if (err_step != ST_OK)
        begin
            final_status = err_step;
        end
        else if (phase_step == PH_WHOLE || phase_step == PH_FRAC)
        begin
            final_status = ST_OK;
        end
        else
        begin
            final_status = ST_INVALID;
        end
    end

    // State update: last transaction hands off a snapshot and clears the state
    always_comb
    begin
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        whole_next      = whole_reg;
        frac_next       = frac_reg;
        cnt_next        = cnt_reg;
        err_next        = err_reg;
        snap_next       = snap_reg;
        snap_valid_next = snap_valid_reg && !snap_ready;
        if (in_fire)
        begin
            if (last)
            begin
                phase_next       = PH_START;
                neg_next         = 1'b0;
                whole_next       = '0;
                frac_next        = '0;
                cnt_next         = '0;
                err_next         = ST_OK;
                snap_next.neg    = neg_step;
                snap_next.whole  = whole_step;
                snap_next.frac   = frac_step;
                snap_next.status = final_status;
                snap_valid_next  = 1'b1;
            end
            else
            begin
                phase_next = phase_step;
                neg_next   = neg_step;
                whole_next = whole_step;
                frac_next  = frac_step;
                cnt_next   = cnt_step;
                err_next   = err_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            neg_reg        <= 1'b0;
            whole_reg      <= '0;
            frac_reg       <= '0;
            cnt_reg        <= '0;
            err_reg        <= ST_OK;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            neg_reg        <= neg_next;
            whole_reg      <= whole_next;
            frac_reg       <= frac_next;
            cnt_reg        <= cnt_next;
            err_reg        <= err_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    // Snapshot payload
    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    // An error stays put until the end of the string
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ST_OK && !(in_fire && last)) |=> (err_reg == $past(err_reg)))
        else $error("error code changed before end of string");

    // Fraction digit count never passes the scale
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FRAC_DIGITS))
        else $error("fraction digit count out of range");

    // A waiting snapshot is not overwritten
    a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid_reg && !snap_ready) |=> (snap_valid_reg && $stable(snap_reg)))
        else $error("pending snapshot lost");

endmodule

// ----- hw/rtl/dtfp_scale.sv -----
module dtfp_scale
    import dtfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               snap_valid,
    output logic               snap_ready,
    input  snap_t              snap,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] micros,
    output logic [1:0]         status
);

    logic        mag_valid_reg, mag_valid_next;
    logic [63:0] mag_reg, mag_next;
    logic        mneg_reg, mneg_next;
    status_t     mstat_reg, mstat_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] micros_reg, micros_next;
    status_t     status_reg, status_next;

    logic        mag_ready;
    logic        mag_fire;
    logic        snap_fire;
    logic        over;

    assign mag_ready  = !out_valid_reg || out_ready;
    assign snap_ready = !mag_valid_reg || mag_ready;
    assign snap_fire  = snap_valid && snap_ready;
    assign mag_fire   = mag_valid_reg && mag_ready;

    // Magnitude: integer part scaled plus the pre-aligned fraction
    always_comb
    begin
        mag_next   = mag_reg;
        mneg_next  = mneg_reg;
        mstat_next = mstat_reg;
        if (snap_fire)
        begin
            mag_next   = 64'(snap.whole) * SCALE + 64'(snap.frac);
            mneg_next  = snap.neg;
            mstat_next = snap.status;
        end
        mag_valid_next = snap_fire || (mag_valid_reg && !mag_ready);
    end

    // Range check and sign
    assign over = mneg_reg ? (mag_reg > I64_MIN_MAG) : (mag_reg > I64_MAX);

    always_comb
    begin
        micros_next = micros_reg;
        status_next = status_reg;
        if (mag_fire)
        begin
            if (mstat_reg != ST_OK)
            begin
                status_next = mstat_reg;
                micros_next = 64'd0;
            end
            else if (over)
            begin
                status_next = ST_OVERFLOW;
                micros_next = 64'd0;
            end
            else
            begin
                status_next = ST_OK;
                micros_next = mneg_reg ? (64'd0 - mag_reg) : mag_reg;
            end
        end
        out_valid_next = mag_fire || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mag_valid_reg <= mag_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        mneg_reg   <= mneg_next;
        mstat_reg  <= mstat_next;
        micros_reg <= micros_next;
        status_reg <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign micros    = $signed(micros_reg);
    assign status    = status_reg;

    // Any error result carries a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |-> (micros_reg == 64'd0))
        else $error("non-zero value with error status");

    // Stalled magnitude stage keeps its contents
    a_mag_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (mag_valid_reg && !mag_ready) |=> (mag_valid_reg && $stable(mag_reg)))
        else $error("magnitude stage lost data");

endmodule

// ----- hw/rtl/decimal_text_to_fixed_point_top.sv -----
// Streaming decimal-to-fixed-point parser. One character is taken per transaction on the
// in_* channel (none when no_char is set), and a transaction may follow every cycle while
// in_ready is high; a transaction with last set ends the string and yields one result
// on the out_* channel: micros in units of 10^-6, two's complement, with status 0 ok,
// 1 invalid format, 2 overflow (micros is zero on error). The string passes a snapshot
// register, loaded at the edge that takes the last transaction, then a stage that scales
// the integer part by one million and adds the fraction, and then the output register
// that does the range check and sign.
// in_ready falls only when all three stages are full and out_ready is low.
module decimal_text_to_fixed_point_top
    import dtfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_code,
    input  logic               no_char,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] micros,
    output logic [1:0]         status
);

    logic  snap_valid;
    logic  snap_ready;
    snap_t snap;

    // Character scanner
    dtfp_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .no_char    (no_char),
        .last       (last),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready)
    );

    // Scaling and range check
    dtfp_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .micros     (micros),
        .status     (status)
    );

endmodule
